FILE: rtl/greedy_box_nms_unit_defines.svh
// Assertion macros used by the top-level RTL of the NMS unit.
`ifndef GREEDY_BOX_NMS_UNIT_DEFINES_SVH
`define GREEDY_BOX_NMS_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define GBN_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: label");

// An antecedent that implies a consequent in the same cycle.
`define GBN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// An antecedent that implies a consequent in the next cycle.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: rtl/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the greedy box NMS unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned THR_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_BIAS = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic        [15:0] score;
    logic               last_box;
  } gbn_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] kept_index;
    logic             last_kept;
  } gbn_out_t;

  // Reference box held while one pair sweep runs.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [35:0] area;
  } gbn_abox_t;

  // One candidate entering the overlap pipeline.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [63:0]      box;
  } gbn_cand_t;

  // Verdict leaving the overlap pipeline.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } gbn_hit_t;

endpackage
`default_nettype wire

FILE: rtl/gbn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in the same cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/gbn_iou_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_iou_pipe
// Five-stage overlap test of one candidate against the reference box:
// inter * 65536 >= threshold * union, with a positive union.
// ----------------------------------------------------------------------------
module gbn_iou_pipe
  import gbn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gbn_abox_t        abox,
  input  wire logic             bias,
  input  wire logic [THR_W-1:0] thr,
  input  wire gbn_cand_t        cand,
  output gbn_hit_t              res,
  output logic                  busy
);

  logic [4:0] vld_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;

  // stage 1 signals
  logic signed [17:0] bl, bt, br, bb, x1, y1, x2, y2, iw_s, ih_s, b18;
  logic [16:0] iw_r, ih_r;
  logic signed [17:0] wb_r, hb_r;
  // stage 2
  logic [33:0] inter2_r;
  logic signed [35:0] areab_r;
  // stage 3
  logic [33:0] inter3_r;
  logic signed [37:0] uni_s;
  logic signed [37:0] uni_r;
  // stage 4
  logic [33:0] inter4_r;
  logic        pos_r;
  logic [33:0] plo_r, phi_r;
  // stage 5
  logic [51:0] lhs, rhs;
  logic        hit_r;

  assign b18 = {17'd0, bias};
  assign bl  = 18'($signed(cand.box[15:0]));
  assign bt  = 18'($signed(cand.box[31:16]));
  assign br  = 18'($signed(cand.box[47:32]));
  assign bb  = 18'($signed(cand.box[63:48]));

  // Intersection corners and extents
  always_comb begin
    x1 = (18'(abox.left) > bl) ? 18'(abox.left) : bl;
    y1 = (18'(abox.top) > bt) ? 18'(abox.top) : bt;
    x2 = (18'(abox.right) < br) ? 18'(abox.right) : br;
    y2 = (18'(abox.bottom) < bb) ? 18'(abox.bottom) : bb;
    iw_s = x2 - x1 + b18;
    ih_s = y2 - y1 + b18;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], cand.vld};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    idx1_r <= cand.idx;
    iw_r   <= iw_s[17] ? 17'd0 : iw_s[16:0];
    ih_r   <= ih_s[17] ? 17'd0 : ih_s[16:0];
    wb_r   <= br - bl + b18;
    hb_r   <= bb - bt + b18;

    idx2_r   <= idx1_r;
    inter2_r <= iw_r * ih_r;
    areab_r  <= wb_r * hb_r;

    idx3_r   <= idx2_r;
    inter3_r <= inter2_r;
    uni_r    <= uni_s;

    idx4_r   <= idx3_r;
    inter4_r <= inter3_r;
    pos_r    <= !uni_r[37] && (uni_r != '0);
    plo_r    <= thr * uni_r[16:0];
    phi_r    <= thr * uni_r[33:17];

    idx5_r <= idx4_r;
    hit_r  <= pos_r && (lhs >= rhs);
  end

  assign uni_s = 38'(abox.area) + 38'(areab_r) - $signed({4'd0, inter2_r});
  assign lhs   = {2'd0, inter4_r, 16'd0};
  assign rhs   = {1'b0, phi_r, 17'd0} + {18'd0, plo_r};

  assign res.vld = vld_r[4];
  assign res.hit = hit_r;
  assign res.idx = idx5_r;
  assign busy    = |vld_r;

endmodule
`default_nettype wire

FILE: rtl/greedy_box_nms_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy non-maximum suppression over a set of up to MAX_BOXES boxes.
// ----------------------------------------------------------------------------
// Boxes load one beat per cycle into a box RAM and a score RAM. The beat with
// last_box set starts suppression, during which in_stall is high. Each round
// scans the score RAM for the highest-scoring box that is neither kept nor
// suppressed, loads it, then sweeps all N boxes through a five-stage overlap
// pipeline. The kept indices then stream out in ascending order unless
// out_stall holds them, and in_stall stays high until the last one is
// issued. Configuration is taken at once.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_unit_defines.svh"
module greedy_box_nms_unit
  import gbn_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire gbn_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output gbn_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_ARD   = 7'b0000100,
    ST_ALOAD = 7'b0001000,
    ST_AMUL  = 7'b0010000,
    ST_PAIR  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [THR_W-1:0]     thr_r;
  logic                 bias_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [MAX_BOXES-1:0] vis_r, vis_nxt, supp_r, supp_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        best_r, best_nxt;
  logic [15:0]          best_sc_r, best_sc_nxt;
  gbn_abox_t            abox_r;
  logic signed [17:0]   wa_r, ha_r;
  logic                 out_valid_r, out_valid_nxt;
  gbn_out_t             out_r, out_nxt;

  logic          accept, store;
  logic          ram_we;
  logic [AW-1:0] waddr, box_raddr;
  logic [63:0]   box_rdata;
  logic [15:0]   sc_rdata;
  logic          ptr_live;
  logic          out_free;
  logic          above;
  logic          pipe_busy;
  gbn_cand_t     cand;
  gbn_hit_t      hit;
  logic [17:0]   b18;

  assign accept    = in_valid && !in_stall;
  assign store     = accept && (cnt_r < MAX_CNT);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_we    = store;
  assign waddr     = cnt_r[AW-1:0];
  assign ptr_live  = (ptr_r < cnt_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign box_raddr = (state_r == ST_ARD) ? best_r : ptr_r[AW-1:0];
  assign b18       = {17'd0, bias_r};

  gbn_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_data.bottom, in_data.right, in_data.top, in_data.left}),
    .raddr (box_raddr),
    .rdata (box_rdata)
  );

  gbn_ram #(.WIDTH(16), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_data.score),
    .raddr (ptr_r[AW-1:0]),
    .rdata (sc_rdata)
  );

  assign cand.vld = rd_vld_r && (state_r == ST_PAIR);
  assign cand.idx = IDX_W'(rd_idx_r);
  assign cand.box = box_rdata;

  gbn_iou_pipe u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .abox  (abox_r),
    .bias  (bias_r),
    .thr   (thr_r),
    .cand  (cand),
    .res   (hit),
    .busy  (pipe_busy)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      bias_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        CFG_AREA_BIAS: bias_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Any kept box above the current output position
  always_comb begin
    above = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      if (vis_r[k] && (CW'(k) > ptr_r)) begin
        above = 1'b1;
      end
    end
  end

  // Sequencer: load, scan, reference load, pair sweep, output
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = ptr_r[AW-1:0];
    vis_nxt       = vis_r;
    supp_nxt      = supp_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_sc_nxt   = best_sc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (store) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (accept && in_data.last_box) begin
          state_nxt = ST_SCAN;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue score reads, pick the best live box as data returns
        if (ptr_live) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
        end
        if (rd_vld_r && !vis_r[rd_idx_r] && !supp_r[rd_idx_r] &&
            (!found_r || (sc_rdata > best_sc_r))) begin
          found_nxt   = 1'b1;
          best_nxt    = rd_idx_r;
          best_sc_nxt = sc_rdata;
        end
        if (!ptr_live && !rd_vld_r) begin
          ptr_nxt = '0;
          if (found_r) begin
            state_nxt = ST_ARD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_ARD: begin
        vis_nxt[best_r] = 1'b1;
        state_nxt       = ST_ALOAD;
      end
      ST_ALOAD: state_nxt = ST_AMUL;
      ST_AMUL: begin
        state_nxt = ST_PAIR;
        ptr_nxt   = '0;
      end
      ST_PAIR: begin
        if (ptr_live) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
        end
        if (!ptr_live && !rd_vld_r && !pipe_busy) begin
          state_nxt = ST_SCAN;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        // stream kept positions in ascending order
        if (ptr_live) begin
          if (!vis_r[ptr_r[AW-1:0]]) begin
            ptr_nxt = ptr_r + 1'b1;
          end else if (out_free) begin
            out_valid_nxt      = 1'b1;
            out_nxt.kept_index = IDX_W'(ptr_r[AW-1:0]);
            out_nxt.last_kept  = !above;
            ptr_nxt            = ptr_r + 1'b1;
          end
        end else begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
          vis_nxt   = '0;
          supp_nxt  = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Mark overlapping candidates suppressed
    if (hit.vld && hit.hit && !vis_r[hit.idx[AW-1:0]]) begin
      supp_nxt[hit.idx[AW-1:0]] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      vis_r       <= '0;
      supp_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      vis_r       <= vis_nxt;
      supp_r      <= supp_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    best_r    <= best_nxt;
    best_sc_r <= best_sc_nxt;
    out_r     <= out_nxt;
    if (state_r == ST_ALOAD) begin
      abox_r.left   <= box_rdata[15:0];
      abox_r.top    <= box_rdata[31:16];
      abox_r.right  <= box_rdata[47:32];
      abox_r.bottom <= box_rdata[63:48];
      wa_r <= 18'($signed(box_rdata[47:32])) - 18'($signed(box_rdata[15:0])) + b18;
      ha_r <= 18'($signed(box_rdata[63:48])) - 18'($signed(box_rdata[31:16])) + b18;
    end
    if (state_r == ST_AMUL) begin
      abox_r.area <= wa_r * ha_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `GBN_ASSERT_ALWAYS(a_kept_not_supp, clk, rst_n, (vis_r & supp_r) == '0)
  `GBN_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= MAX_CNT)
  `GBN_ASSERT_IMPLY(a_ref_kept, clk, rst_n, state_r == ST_PAIR, vis_r[best_r])
  `GBN_ASSERT_NEXT(a_idle_clear, clk, rst_n, (state_r == ST_OUT) && !ptr_live, vis_r == '0)

endmodule
`default_nettype wire
